// ===== rtl/core/sebs_pkg.sv =====
// Shared types and constants for the size-ordered subset enumerator.
// No dependencies; compiled first.
package sebs_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 32;
	localparam int unsigned MASK_W        = 32;
	localparam int unsigned SIZE_W        = 6;

	localparam logic [1:0] OP_NEXT    = 2'd0;
	localparam logic [1:0] OP_LOAD    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_END = 1'b1;

	typedef struct packed {
		logic [1:0]        op;
		logic [MASK_W-1:0] load_mask;
	} cmd_t;

	typedef struct packed {
		logic [MASK_W-1:0] subset_mask;
		logic              status;
	} result_t;

	typedef logic [SIZE_W-1:0] width_cfg_t;

endpackage

// ===== rtl/core/sebs_chan_if.sv =====
// Valid/ready channel carrying one payload of type T.
// Used by the subset enumerator for command, result and configuration.
interface sebs_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/subset_enumerator_by_size.sv =====
// Size-ordered subset enumerator: top level.
// Depends on sebs_pkg and sebs_chan_if.

// Steps through the subsets of a set_width-bit set, by size and then by the
// next-combination rule; load and restart items set the state directly. One
// item is taken every clock cycle while the result is not stalled, and its
// result passes from the input register to the result register. The cycle is
// set by the next-combination path: two 32-bit adds, a lowest-bit encode and a
// barrel shift between the input register and the state/result registers. The
// width register is written through cfg, which is always ready.
module subset_enumerator_by_size
	import sebs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sebs_chan_if.sink                         cfg,
	sebs_chan_if.sink                         cmd,
	sebs_chan_if.source                       result
);

	localparam logic [SIZE_W-1:0] WMAX     = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

	logic [SIZE_W-1:0] width_q;
	logic [MASK_W-1:0] cur_q;
	logic [SIZE_W-1:0] size_q;

	logic              s1_valid;
	cmd_t              cmd_s1;
	logic              out_valid_q;
	result_t           out_q;

	logic              advance;

	assign advance      = s1_valid && (!out_valid_q || result.ready);
	assign cmd.ready    = !s1_valid || advance;
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// effective width and its mask
	logic [SIZE_W-1:0] w_eff;
	logic [MASK_W-1:0] low_mask;

	assign w_eff = (width_q > WMAX) ? WMAX : width_q;

	function automatic logic [MASK_W-1:0] low_ones(input logic [SIZE_W-1:0] n);
		logic [MASK_W-1:0] r;
		r = '0;
		for (int i = 0; i < MASK_W; i++) begin
			r[i] = (SIZE_W'(i) < n);
		end
		return r;
	endfunction

	assign low_mask = low_ones(w_eff);

	// next combination within the low w_eff bits
	logic [MASK_W-1:0] mw;
	logic [MASK_W-1:0] lowest;
	logic [MASK_W:0]   ripple;
	logic [MASK_W-1:0] pbit;
	logic [MASK_W:0]   moved;
	logic [4:0]        tz;
	logic              found;
	logic [MASK_W-1:0] packed_ones;
	logic [MASK_W-1:0] next_comb;

	assign mw     = cur_q & low_mask;
	assign lowest = mw & (~mw + MASK_W'(1));
	assign ripple = {1'b0, mw} + {1'b0, lowest};
	assign pbit   = ripple[MASK_W-1:0] & ~mw;
	assign found  = |(pbit & low_mask);
	assign moved  = ripple ^ {1'b0, mw};

	// encode the one-hot lowest bit
	always_comb begin
		tz = '0;
		for (int b = 0; b < 5; b++) begin
			for (int i = 0; i < MASK_W; i++) begin
				if (((i >> b) & 1) == 1) begin
					tz[b] = tz[b] | lowest[i];
				end
			end
		end
	end

	// the run's remaining ones, repacked at the bottom
	assign packed_ones = MASK_W'((moved >> 2) >> tz);
	assign next_comb   = (cur_q & ~low_mask) | ripple[MASK_W-1:0] | packed_ones;

	// population count for loads, summed as a tree
	logic [MASK_W-1:0] load_kept;
	logic [SIZE_W-1:0] load_cnt;
	logic [2:0]        nib_cnt [8];
	logic [3:0]        byte_cnt [4];
	logic [4:0]        half_cnt [2];

	assign load_kept = cmd_s1.load_mask & low_mask;

	always_comb begin
		for (int g = 0; g < 8; g++) begin
			nib_cnt[g] = 3'(load_kept[4*g]) + 3'(load_kept[4*g+1])
				+ 3'(load_kept[4*g+2]) + 3'(load_kept[4*g+3]);
		end
		for (int g = 0; g < 4; g++) begin
			byte_cnt[g] = 4'(nib_cnt[2*g]) + 4'(nib_cnt[2*g+1]);
		end
		for (int g = 0; g < 2; g++) begin
			half_cnt[g] = 5'(byte_cnt[2*g]) + 5'(byte_cnt[2*g+1]);
		end
		load_cnt = SIZE_W'(half_cnt[0]) + SIZE_W'(half_cnt[1]);
	end

	// state update for the item in the input register
	logic [MASK_W-1:0] cur_d;
	logic [SIZE_W-1:0] size_d;
	logic [SIZE_W-1:0] size_inc;
	logic              status_d;

	assign size_inc = (size_q == SIZE_SAT) ? size_q : size_q + SIZE_W'(1);

	always_comb begin
		cur_d    = cur_q;
		size_d   = size_q;
		status_d = STATUS_OK;
		unique case (cmd_s1.op)
			OP_NEXT: begin
				if (found) begin
					cur_d = next_comb;
				end else begin
					size_d = size_inc;
					if (size_inc > w_eff) begin
						cur_d    = '0;
						status_d = STATUS_END;
					end else begin
						cur_d = low_ones(size_inc);
					end
				end
			end
			OP_LOAD: begin
				cur_d  = load_kept;
				size_d = load_cnt;
			end
			OP_RESTART: begin
				cur_d  = '0;
				size_d = '0;
			end
			default: begin
				// unused code: hold state, report current mask
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= '0;
			cur_q       <= '0;
			size_q      <= '0;
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				width_q <= cfg.data;
			end
			if (cmd.ready) begin
				s1_valid <= cmd.valid;
			end
			if (advance) begin
				cur_q       <= cur_d;
				size_q      <= size_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
		if (advance) begin
			out_q.subset_mask <= cur_d;
			out_q.status      <= status_d;
		end
	end

	// an end report always carries the empty mask
	a_end_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status |-> out_q.subset_mask == '0)
		else $error("end status with nonzero mask");

	// a held item in the input register is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |=> s1_valid && $stable(cmd_s1))
		else $error("stalled item lost from input register");

	// restart clears the state
	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1.op == OP_RESTART |=> cur_q == '0 && size_q == '0)
		else $error("restart did not clear state");

	// the result mask tracks the stored subset when the result is written
	a_out_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_q.subset_mask == cur_q)
		else $error("result mask differs from stored subset");

endmodule
